FILE: rtl/core/sir_pkg.sv
// Shared constants and fixed-point helpers for the SIR Euler step block.
`timescale 1ns / 1ps
package sir_pkg;
  localparam int CW = 31;                   // compartment width, Q17.14
  localparam int TW = 32;                   // time width, Q16.16
  localparam int RW = 16;                   // rate register width
  localparam int QW = 64;                   // dividend width of the divider
  localparam int DW = 33;                   // divisor width of the divider
  localparam int SW = 4 * CW + TW + 1;      // side-band width of the divider
  localparam logic [CW-1:0] MAXC = {CW{1'b1}};

  typedef enum logic [1:0] {
    REG_CONTACT    = 2'd0,
    REG_RECOVERY   = 2'd1,
    REG_STEP       = 2'd2,
    REG_POPULATION = 2'd3
  } reg_idx_t;

  // Saturate a wide unsigned value to the compartment range.
  function automatic logic [CW-1:0] sat31(input logic [QW-1:0] x);
    logic [CW-1:0] r;
    r = (x > QW'(MAXC)) ? MAXC : x[CW-1:0];
    return r;
  endfunction
endpackage

FILE: rtl/core/sir_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sir_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [sir_pkg::QW-1:0]   dividend,
  input  logic [sir_pkg::DW-1:0]   divisor,
  input  logic [sir_pkg::SW-1:0]   side_in,
  output logic                     out_valid,
  output logic [sir_pkg::QW-1:0]   quotient,
  output logic [sir_pkg::SW-1:0]   side_out
);
  import sir_pkg::*;

  logic [QW-1:0]    q   [0:QW];
  logic [DW:0]      rem [0:QW];
  logic [DW-1:0]    dv  [0:QW];
  logic [SW-1:0]    sd  [0:QW];
  logic [QW:0]      vl;

  assign q[0] = dividend;
  assign rem[0] = '0;
  assign dv[0] = divisor;
  assign sd[0] = side_in;
  assign vl[0] = in_valid;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] sh;
    logic [DW:0] df;
    assign sh = {rem[k][DW-1:0], q[k][QW-1]};
    assign df = sh - {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (rst) vl[k+1] <= 1'b0;
      else vl[k+1] <= vl[k];
      if (sh >= {1'b0, dv[k]}) begin
        rem[k+1] <= df;
        q[k+1] <= {q[k][QW-2:0], 1'b1};
      end else begin
        rem[k+1] <= sh;
        q[k+1] <= {q[k][QW-2:0], 1'b0};
      end
      dv[k+1] <= dv[k];
      sd[k+1] <= sd[k];
    end
  end

  assign out_valid = vl[QW];
  assign quotient = q[QW];
  assign side_out = sd[QW];
endmodule

FILE: rtl/core/sir_epidemic_euler_step.sv
// Top level of the pipelined SIR forward-Euler step.
//   channel  | ports                                              | handshake
//   request  | susceptible_in infected_in recovered_in time_in   | start, busy
//   result   | susceptible_out infected_out recovered_out        | done strobe
//            | time_out zero_total                                |
//   config   | cfg_index cfg_data                                 | cfg_we
// One request enters every cycle; busy is always low. The pipeline holds
// 4 multiply stages, a 64-stage divider, a clamp stage, a product stage, a
// second 64-stage divider and an output register; the dividers resolve one
// quotient bit per stage. Reset clears the valid pipeline and loads the
// register defaults. The receiver cannot stall, so nothing holds.
`timescale 1ns / 1ps
module sir_epidemic_euler_step (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [sir_pkg::CW-1:0]  susceptible_in,
  input  logic [sir_pkg::CW-1:0]  infected_in,
  input  logic [sir_pkg::CW-1:0]  recovered_in,
  input  logic [sir_pkg::TW-1:0]  time_in,
  output logic                    done,
  output logic [sir_pkg::CW-1:0]  susceptible_out,
  output logic [sir_pkg::CW-1:0]  infected_out,
  output logic [sir_pkg::CW-1:0]  recovered_out,
  output logic [sir_pkg::TW-1:0]  time_out,
  output logic                    zero_total,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [30:0]             cfg_data
);
  import sir_pkg::*;

  logic [RW-1:0] contact_rate, recovery_rate, step_size;
  logic [CW-1:0] population_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_rate <= RW'(5325);
      recovery_rate <= RW'(2048);
      step_size <= RW'(655);
      population_total <= CW'(1638400000);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CONTACT:    contact_rate <= cfg_data[RW-1:0];
        REG_RECOVERY:   recovery_rate <= cfg_data[RW-1:0];
        REG_STEP:       step_size <= cfg_data[RW-1:0];
        REG_POPULATION: population_total <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: h*g, carry inputs, advance time by h
  logic          v1;
  logic [31:0]   hg1;
  logic [CW-1:0] s1, i1, r1;
  logic [TW-1:0] t1;
  always_ff @(posedge clk) begin
    v1 <= rst ? 1'b0 : start;
    hg1 <= step_size * recovery_rate;
    s1 <= susceptible_in; i1 <= infected_in; r1 <= recovered_in;
    t1 <= time_in + TW'(step_size);
  end

  // stage 2: rec = round(hg*i >> 28)
  logic          v2;
  logic [CW-1:0] rec2, s2, i2, r2;
  logic [TW-1:0] t2;
  logic [62:0]   p2;
  assign p2 = hg1 * i1 + 63'(1 << 27);
  always_ff @(posedge clk) begin
    v2 <= rst ? 1'b0 : v1;
    rec2 <= sat31(QW'(p2 >> 28));
    s2 <= s1; i2 <= i1; r2 <= r1; t2 <= t1;
  end

  // stage 3: bt = round(rec*b >> 12)
  logic          v3;
  logic [CW-1:0] bt3, rec3, s3, i3, r3;
  logic [TW-1:0] t3;
  logic [47:0]   p3;
  assign p3 = rec2 * contact_rate + 48'(1 << 11);
  always_ff @(posedge clk) begin
    v3 <= rst ? 1'b0 : v2;
    bt3 <= sat31(QW'(p3 >> 12));
    rec3 <= rec2; s3 <= s2; i3 <= i2; r3 <= r2; t3 <= t2;
  end

  // stage 4: bt*s
  logic          v4;
  logic [61:0]   bs4;
  logic [CW-1:0] rec4, s4, i4, r4;
  logic [TW-1:0] t4;
  always_ff @(posedge clk) begin
    v4 <= rst ? 1'b0 : v3;
    bs4 <= bt3 * s3;
    rec4 <= rec3; s4 <= s3; i4 <= i3; r4 <= r3; t4 <= t3;
  end

  // divide bt*s by population; side carries rec, s, i, r, t
  logic          vd1;
  logic [QW-1:0] qd1;
  logic [SW-1:0] sd1;
  sir_div u_div_inf (
    .clk(clk), .rst(rst), .in_valid(v4),
    .dividend(QW'(bs4)), .divisor(DW'(population_total)),
    .side_in({rec4, s4, i4, r4, 1'b0, t4}),
    .out_valid(vd1), .quotient(qd1), .side_out(sd1)
  );

  // stage 5: inf, new compartments, total
  logic [CW-1:0] inf5, rec5, s5, i5, r5;
  logic [TW-1:0] t5;
  assign {rec5, s5, i5, r5} = sd1[SW-1:TW+1];
  assign t5 = sd1[TW-1:0];
  assign inf5 = (population_total == '0) ? MAXC : sat31(qd1);

  logic          v6;
  logic [CW-1:0] sn6, in6, rn6;
  logic [DW-1:0] tot6;
  logic [TW-1:0] t6;
  logic [33:0]   isum;
  logic [CW:0]   rsum;
  logic [CW-1:0] sn, inn, rn;
  always_comb begin
    sn = (s5 > inf5) ? s5 - inf5 : '0;
    isum = 34'(i5) + 34'(inf5);
    inn = (isum > 34'(rec5)) ? sat31(QW'(isum - 34'(rec5))) : '0;
    rsum = {1'b0, r5} + {1'b0, rec5};
    rn = sat31(QW'(rsum));
  end
  always_ff @(posedge clk) begin
    v6 <= rst ? 1'b0 : vd1;
    sn6 <= sn; in6 <= inn; rn6 <= rn; t6 <= t5;
    tot6 <= DW'(sn) + DW'(inn) + DW'(rn);
  end

  // stage 7: x*pop products
  logic          v7;
  logic [61:0]   ps7, pi7, pr7;
  logic [DW-1:0] tot7;
  logic [TW-1:0] t7;
  always_ff @(posedge clk) begin
    v7 <= rst ? 1'b0 : v6;
    ps7 <= sn6 * population_total;
    pi7 <= in6 * population_total;
    pr7 <= rn6 * population_total;
    tot7 <= tot6; t7 <= t6;
  end

  logic          vs, vi, vr;
  logic [QW-1:0] qs, qi, qr;
  logic [SW-1:0] ss;
  sir_div u_div_s (
    .clk(clk), .rst(rst), .in_valid(v7), .dividend(QW'(ps7)), .divisor(tot7),
    .side_in({{(SW-TW-1){1'b0}}, (tot7 == '0), t7}), .out_valid(vs), .quotient(qs),
    .side_out(ss)
  );
  sir_div u_div_i (
    .clk(clk), .rst(rst), .in_valid(v7), .dividend(QW'(pi7)), .divisor(tot7),
    .side_in('0), .out_valid(vi), .quotient(qi), .side_out()
  );
  sir_div u_div_r (
    .clk(clk), .rst(rst), .in_valid(v7), .dividend(QW'(pr7)), .divisor(tot7),
    .side_in('0), .out_valid(vr), .quotient(qr), .side_out()
  );

  logic zt;
  assign zt = ss[TW];
  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : (vs & vi & vr);
    susceptible_out <= zt ? '0 : qs[CW-1:0];
    infected_out <= zt ? '0 : qi[CW-1:0];
    recovered_out <= zt ? '0 : qr[CW-1:0];
    time_out <= ss[TW-1:0];
    zero_total <= zt;
  end
endmodule
